// File: hw/rtl/ndtm_pkg.sv
package ndtm_pkg;

    // Field widths
    localparam int DIST_W  = 16;
    localparam int RATE_W  = 8;
    localparam int SPEED_W = 24;
    localparam int CLASS_W = 3;
    localparam int REG_IDX_W = 2;

    // A difference of 10 m (Q4.12) or more never matches.
    localparam logic [DIST_W-1:0] NO_MATCH_DIFF = 16'd40960;

    // Register reset values
    localparam logic [RATE_W-1:0]  FRAME_RATE_RST     = 8'd10;
    localparam logic [DIST_W-1:0]  MOVEMENT_LIMIT_RST = 16'd1229;
    localparam logic [SPEED_W-1:0] STATIC_SPEED_RST   = 24'd410;
    localparam logic [SPEED_W-1:0] FAST_SPEED_RST     = 24'd12288;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FRAME_RATE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOVEMENT_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STATIC_SPEED   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_FAST_SPEED     = 2'd3;

    // Input item kinds
    localparam logic OP_CLUSTER   = 1'b0;
    localparam logic OP_FRAME_END = 1'b1;

    // Result classes
    typedef enum logic [CLASS_W-1:0] {
        CLS_UNTRACKED = 3'd0,
        CLS_NEW       = 3'd1,
        CLS_STATIC    = 3'd2,
        CLS_MOVING    = 3'd3,
        CLS_FAST      = 3'd4
    } speed_class_t;

    // Configuration register set
    typedef struct packed {
        logic [RATE_W-1:0]  frame_rate_hz;
        logic [DIST_W-1:0]  movement_limit;
        logic [SPEED_W-1:0] static_speed;
        logic [SPEED_W-1:0] fast_speed;
    } cfg_t;

endpackage

// File: hw/rtl/nearest_distance_track_matcher.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: cluster_distance; s_tuser: op
// m_*       out  m_tvalid/m_tready    m_tdata: speed; m_tuser: speed_class
// cfg_*     in   cfg_valid/cfg_ready  cfg_index: register; cfg_data: value
//
// A cluster item is accepted, then steps through each stored slot in turn on the
// shared difference/compare unit, then takes the rate multiply and then loads
// the output register. An end-of-frame item is done in its accept step.
// A cluster beyond MAX_TRACKED in a frame skips the slot search and the multiply.
// Reset clears the slot valid bits and the frame count; no clearing pass.
// s_tready is low while an item is in work; a new result holds in the emit step
// while the previous one still waits on m_tready.
module nearest_distance_track_matcher
#(
    parameter int MAX_TRACKED = 2
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [ndtm_pkg::DIST_W-1:0]            s_tdata,   // [15:0] cluster_distance
    input  logic                                   s_tuser,   // [0] op
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [ndtm_pkg::SPEED_W-1:0]           m_tdata,   // [23:0] speed
    output logic [ndtm_pkg::CLASS_W-1:0]           m_tuser,   // [2:0] speed_class
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ndtm_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [ndtm_pkg::SPEED_W-1:0]           cfg_data
);

    localparam int IDX_W = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
    localparam int CNT_W = $clog2(MAX_TRACKED + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_TRACKED - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_TRACKED);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SCALE  = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    ndtm_pkg::cfg_t cfg;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                cnt_reg;
    logic [IDX_W-1:0]                slot_reg;
    logic [IDX_W-1:0]                best_idx_reg;
    logic                            found_reg;
    logic                            untracked_reg;
    logic [MAX_TRACKED-1:0]          prev_valid_reg;
    logic [ndtm_pkg::DIST_W-1:0]     prev_dist_reg [MAX_TRACKED];
    logic [ndtm_pkg::DIST_W-1:0]     cur_dist_reg [MAX_TRACKED];
    logic [ndtm_pkg::DIST_W-1:0]     dist_reg;
    logic [ndtm_pkg::DIST_W-1:0]     best_reg;
    logic [ndtm_pkg::SPEED_W-1:0]    product_reg;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [ndtm_pkg::SPEED_W-1:0]    m_speed_reg;
    logic [ndtm_pkg::CLASS_W-1:0]    m_class_reg;

    logic                            s_xfer;
    logic                            out_free;
    logic [ndtm_pkg::DIST_W-1:0]     diff;
    logic                            take;
    logic [ndtm_pkg::SPEED_W-1:0]    res_speed;
    ndtm_pkg::speed_class_t          res_class;

    // Configuration registers
    ndtm_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Shared difference/compare unit, one stored slot per cycle
    ndtm_match_unit u_match_unit
    (
        .slot_valid     (prev_valid_reg[slot_reg]),
        .cur_dist       (dist_reg),
        .prev_dist      (prev_dist_reg[slot_reg]),
        .movement_limit (cfg.movement_limit),
        .best_diff      (best_reg),
        .diff           (diff),
        .take           (take)
    );

    // Result classification from the registered product
    ndtm_classify u_classify
    (
        .untracked    (untracked_reg),
        .found        (found_reg),
        .product      (product_reg),
        .static_speed (cfg.static_speed),
        .fast_speed   (cfg.fast_speed),
        .speed        (res_speed),
        .speed_class  (res_class)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_speed_reg;
    assign m_tuser  = m_class_reg;

    // Output valid: loaded from the emit step, dropped after its transfer.
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        if ((state_reg == ST_EMIT) && out_free)
        begin
            m_valid_next = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer && (s_tuser == ndtm_pkg::OP_CLUSTER))
                begin
                    if (cnt_reg >= CNT_FULL)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            slot_reg       <= '0;
            found_reg      <= 1'b0;
            untracked_reg  <= 1'b0;
            prev_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_xfer)
                    begin
                        if (s_tuser == ndtm_pkg::OP_FRAME_END)
                        begin
                            for (int i = 0; i < MAX_TRACKED; i++)
                            begin
                                prev_valid_reg[i] <= (CNT_W'(i) < cnt_reg);
                            end
                            cnt_reg <= '0;
                        end
                        else
                        begin
                            untracked_reg <= (cnt_reg >= CNT_FULL);
                            found_reg     <= 1'b0;
                            slot_reg      <= '0;
                            if (cnt_reg < CNT_FULL)
                            begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_SEARCH:
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (slot_reg != LAST_SLOT)
                    begin
                        slot_reg <= slot_reg + IDX_W'(1);
                    end
                end
                ST_SCALE:
                begin
                    // The matched slot is used up for this frame.
                    if (found_reg)
                    begin
                        prev_valid_reg[best_idx_reg] <= 1'b0;
                    end
                end
                ST_EMIT:
                begin
                    // Only the output valid moves while the result waits.
                end
                default:
                begin
                    slot_reg <= '0;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_xfer && (s_tuser == ndtm_pkg::OP_FRAME_END))
        begin
            for (int i = 0; i < MAX_TRACKED; i++)
            begin
                if (CNT_W'(i) < cnt_reg)
                begin
                    prev_dist_reg[i] <= cur_dist_reg[i];
                end
            end
        end
        if (s_xfer && (s_tuser == ndtm_pkg::OP_CLUSTER))
        begin
            dist_reg <= s_tdata;
            best_reg <= ndtm_pkg::NO_MATCH_DIFF;
            if (cnt_reg < CNT_FULL)
            begin
                cur_dist_reg[cnt_reg[IDX_W-1:0]] <= s_tdata;
            end
        end
        if ((state_reg == ST_SEARCH) && take)
        begin
            best_reg     <= diff;
            best_idx_reg <= slot_reg;
        end
        if (state_reg == ST_SCALE)
        begin
            product_reg <= ndtm_pkg::SPEED_W'(cfg.frame_rate_hz)
                           * ndtm_pkg::SPEED_W'(best_reg);
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            m_speed_reg <= res_speed;
            m_class_reg <= res_class;
        end
    end

    // The frame count never passes the number of tracked slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
    else $error("frame count above tracked slot count");

    // An end-of-frame item produces no result and frees the input at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (s_tuser == ndtm_pkg::OP_FRAME_END)) |=> (s_tready && !$rose(m_tvalid)))
    else $error("end of frame did not complete in one cycle");

    // A found match always carries a difference below the match ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_reg < ndtm_pkg::NO_MATCH_DIFF))
    else $error("match recorded without a valid difference");

endmodule

// File: hw/rtl/ndtm_cfg_regs.sv
module ndtm_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ndtm_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [ndtm_pkg::SPEED_W-1:0]        cfg_data,
    output ndtm_pkg::cfg_t                      cfg
);

    ndtm_pkg::cfg_t cfg_reg;
    ndtm_pkg::cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ndtm_pkg::REG_FRAME_RATE:
                    cfg_next.frame_rate_hz = cfg_data[ndtm_pkg::RATE_W-1:0];
                ndtm_pkg::REG_MOVEMENT_LIMIT:
                    cfg_next.movement_limit = cfg_data[ndtm_pkg::DIST_W-1:0];
                ndtm_pkg::REG_STATIC_SPEED:
                    cfg_next.static_speed = cfg_data;
                ndtm_pkg::REG_FAST_SPEED:
                    cfg_next.fast_speed = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_rate_hz  <= ndtm_pkg::FRAME_RATE_RST;
            cfg_reg.movement_limit <= ndtm_pkg::MOVEMENT_LIMIT_RST;
            cfg_reg.static_speed   <= ndtm_pkg::STATIC_SPEED_RST;
            cfg_reg.fast_speed     <= ndtm_pkg::FAST_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/ndtm_match_unit.sv
module ndtm_match_unit
(
    input  logic                          slot_valid,
    input  logic [ndtm_pkg::DIST_W-1:0]   cur_dist,
    input  logic [ndtm_pkg::DIST_W-1:0]   prev_dist,
    input  logic [ndtm_pkg::DIST_W-1:0]   movement_limit,
    input  logic [ndtm_pkg::DIST_W-1:0]   best_diff,
    output logic [ndtm_pkg::DIST_W-1:0]   diff,
    output logic                          take
);

    // Absolute difference between the new distance and one stored slot.
    always_comb
    begin
        if (cur_dist >= prev_dist)
        begin
            diff = cur_dist - prev_dist;
        end
        else
        begin
            diff = prev_dist - cur_dist;
        end
    end

    // A slot wins only on a strictly smaller difference inside the limit.
    assign take = slot_valid && (diff <= movement_limit) && (diff < best_diff);

endmodule

// File: hw/rtl/ndtm_classify.sv
module ndtm_classify
(
    input  logic                           untracked,
    input  logic                           found,
    input  logic [ndtm_pkg::SPEED_W-1:0]   product,
    input  logic [ndtm_pkg::SPEED_W-1:0]   static_speed,
    input  logic [ndtm_pkg::SPEED_W-1:0]   fast_speed,
    output logic [ndtm_pkg::SPEED_W-1:0]   speed,
    output ndtm_pkg::speed_class_t         speed_class
);

    // Speed is reported only when the match moves faster than static.
    always_comb
    begin
        speed       = '0;
        speed_class = ndtm_pkg::CLS_NEW;
        if (untracked)
        begin
            speed_class = ndtm_pkg::CLS_UNTRACKED;
        end
        else if (found)
        begin
            if (product > static_speed)
            begin
                speed = product;
                if (product > fast_speed)
                begin
                    speed_class = ndtm_pkg::CLS_FAST;
                end
                else
                begin
                    speed_class = ndtm_pkg::CLS_MOVING;
                end
            end
            else
            begin
                speed_class = ndtm_pkg::CLS_STATIC;
            end
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_TRACKED    = 2;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 12;
    localparam int MAX_MATCH_DIFF = 40959;

    typedef struct {
        logic [ndtm_pkg::SPEED_W-1:0] speed;
        ndtm_pkg::speed_class_t       cls;
    } speed_report_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ndtm_pkg::DIST_W-1:0]    s_tdata;    // [15:0] cluster_distance
    logic                           s_tuser;    // [0] op
    logic                           m_tvalid;
    logic                           m_tready;
    logic [ndtm_pkg::SPEED_W-1:0]   m_tdata;    // [23:0] speed
    logic [ndtm_pkg::CLASS_W-1:0]   m_tuser;    // [2:0] speed_class
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ndtm_pkg::REG_IDX_W-1:0] cfg_index;
    logic [ndtm_pkg::SPEED_W-1:0]   cfg_data;

    // Tracker state mirrored on the testbench side.
    ndtm_pkg::cfg_t              cfg;
    logic [ndtm_pkg::DIST_W-1:0] prev_dist [MAX_TRACKED];
    logic                        prev_live [MAX_TRACKED];
    logic [ndtm_pkg::DIST_W-1:0] cur_dist  [MAX_TRACKED];
    int                          clusters_in_frame;

    // Speed reports still owed by the block, oldest first.
    speed_report_t speed_reports_due[$];

    int mismatches;
    bit idle_on;
    int tx_gap_pct;
    int rx_gap_pct;
    int rx_hold_left;

    nearest_distance_track_matcher #(
        .MAX_TRACKED (MAX_TRACKED)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or results go missing.
    initial
    begin
        #1000000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("tb_top: mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Update the mirrored tracker with one accepted item and, for a cluster, queue its report.
    task automatic match_cluster(input logic op, input logic [ndtm_pkg::DIST_W-1:0] distance);
        logic [ndtm_pkg::DIST_W-1:0]  best;
        logic [ndtm_pkg::DIST_W-1:0]  diff;
        logic [ndtm_pkg::SPEED_W-1:0] v;
        int                           best_slot;
        logic                         found;
        speed_report_t                r;
        if (op == ndtm_pkg::OP_FRAME_END)
        begin
            // This frame's tracked distances become the list to match against.
            for (int i = 0; i < MAX_TRACKED; i++)
            begin
                prev_live[i] = (i < clusters_in_frame);
                if (i < clusters_in_frame)
                    prev_dist[i] = cur_dist[i];
            end
            clusters_in_frame = 0;
            return;
        end
        r.speed = '0;
        if (clusters_in_frame >= MAX_TRACKED)
        begin
            r.cls = ndtm_pkg::CLS_UNTRACKED;
            speed_reports_due = {speed_reports_due, r};
            return;
        end
        cur_dist[clusters_in_frame] = distance;
        clusters_in_frame++;
        // Slot-order search; only a strictly smaller difference replaces the best.
        best      = ndtm_pkg::NO_MATCH_DIFF;
        best_slot = 0;
        found     = 1'b0;
        for (int i = 0; i < MAX_TRACKED; i++)
        begin
            if (prev_live[i])
            begin
                diff = (distance >= prev_dist[i]) ? distance - prev_dist[i]
                                                  : prev_dist[i] - distance;
                if (diff <= cfg.movement_limit && diff < best)
                begin
                    best      = diff;
                    best_slot = i;
                    found     = 1'b1;
                end
            end
        end
        if (!found)
        begin
            r.cls = ndtm_pkg::CLS_NEW;
        end
        else
        begin
            prev_live[best_slot] = 1'b0;
            v = ndtm_pkg::SPEED_W'(cfg.frame_rate_hz) * ndtm_pkg::SPEED_W'(best);
            if (v > cfg.static_speed)
            begin
                r.speed = v;
                r.cls   = (v > cfg.fast_speed) ? ndtm_pkg::CLS_FAST : ndtm_pkg::CLS_MOVING;
            end
            else
            begin
                r.cls = ndtm_pkg::CLS_STATIC;
            end
        end
        speed_reports_due = {speed_reports_due, r};
    endtask

    // Offer one item, wait for its transfer, then maybe leave a gap.
    task automatic send_item(input logic op, input logic [ndtm_pkg::DIST_W-1:0] distance);
        s_tuser  <= op;
        s_tdata  <= distance;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        match_cluster(op, distance);
        if (idle_on && $urandom_range(0, 99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Wait until every owed report has arrived and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (speed_reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keeps cfg_valid high so that consecutive writes stream back to back.
    task automatic write_reg(input logic [ndtm_pkg::REG_IDX_W-1:0] idx,
                             input logic [ndtm_pkg::SPEED_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ndtm_pkg::REG_FRAME_RATE:
                cfg.frame_rate_hz  = value[ndtm_pkg::RATE_W-1:0];
            ndtm_pkg::REG_MOVEMENT_LIMIT:
                cfg.movement_limit = value[ndtm_pkg::DIST_W-1:0];
            ndtm_pkg::REG_STATIC_SPEED:
                cfg.static_speed   = value;
            ndtm_pkg::REG_FAST_SPEED:
                cfg.fast_speed     = value;
            default: ;
        endcase
    endtask

    task automatic load_config(input int rate, input int limit, input int slow, input int fast);
        wait_idle();
        write_reg(ndtm_pkg::REG_FRAME_RATE, ndtm_pkg::SPEED_W'(rate));
        write_reg(ndtm_pkg::REG_MOVEMENT_LIMIT, ndtm_pkg::SPEED_W'(limit));
        write_reg(ndtm_pkg::REG_STATIC_SPEED, ndtm_pkg::SPEED_W'(slow));
        write_reg(ndtm_pkg::REG_FAST_SPEED, ndtm_pkg::SPEED_W'(fast));
        cfg_valid <= 1'b0;
    endtask

    // Mostly distances near a stored one, so that matches and near misses dominate.
    function automatic logic [ndtm_pkg::DIST_W-1:0] pick_distance();
        int slot;
        int base;
        int span;
        int val;
        case ($urandom_range(0, 9))
            0, 1, 2: return ndtm_pkg::DIST_W'($urandom_range(0, 65535));
            3:       return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
            default:
            begin
                slot = $urandom_range(0, MAX_TRACKED - 1);
                base = prev_live[slot] ? int'(prev_dist[slot]) : $urandom_range(0, 65535);
                span = (int'(cfg.movement_limit) > MAX_MATCH_DIFF) ?
                       MAX_MATCH_DIFF + 1 : int'(cfg.movement_limit);
                if ($urandom_range(0, 3) == 0)
                    val = span + $urandom_range(0, 1);
                else
                    val = $urandom_range(0, span + 8);
                val = ($urandom_range(0, 1) == 0) ? base + val : base - val;
                if (val < 0)
                    val = 0;
                if (val > 65535)
                    val = 65535;
                return ndtm_pkg::DIST_W'(val);
            end
        endcase
    endfunction

    // Frames of random content; a few are overlong, empty or missing their end marker.
    task automatic run_frames(input int n_items);
        int sent;
        int n_clusters;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                n_clusters = 0;
            else if (r <= 3)
                n_clusters = $urandom_range(3, 4);
            else
                n_clusters = $urandom_range(1, 2);
            for (int k = 0; k < n_clusters; k++)
            begin
                send_item(ndtm_pkg::OP_CLUSTER, pick_distance());
                sent++;
            end
            if ($urandom_range(0, 9) != 0)
            begin
                send_item(ndtm_pkg::OP_FRAME_END,
                          ndtm_pkg::DIST_W'($urandom_range(0, 65535)));
                sent++;
            end
        end
    endtask

    task automatic random_config();
        int rate;
        int limit;
        int cap;
        int slow;
        int fast;
        case ($urandom_range(0, 5))
            0:       rate = 0;
            1:       rate = 255;
            2:       rate = 1;
            default: rate = $urandom_range(1, 255);
        endcase
        case ($urandom_range(0, 5))
            0:       limit = 0;
            1:       limit = 65535;
            2:       limit = ndtm_pkg::MOVEMENT_LIMIT_RST;
            default: limit = $urandom_range(0, 4095);
        endcase
        cap = rate * ((limit > MAX_MATCH_DIFF) ? MAX_MATCH_DIFF : limit);
        case ($urandom_range(0, 7))
            0:       slow = 0;
            1:       slow = 24'hFFFFFF;
            default: slow = $urandom_range(0, cap);
        endcase
        case ($urandom_range(0, 7))
            0:       fast = 0;
            1:       fast = 24'hFFFFFF;
            default: fast = $urandom_range(0, cap);
        endcase
        load_config(rate, limit, slow, fast);
    endtask

    // Reset register values: new tracks, overflow, static, fast, moving, ties.
    task automatic test_reset_settings();
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'hFFFF);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd12345);
        send_item(ndtm_pkg::OP_FRAME_END, 16'hFFFF);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd64306);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd41);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd64348);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd1271);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd64348);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd1000);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd1200);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        // Equal distance to both stored slots: the first slot takes it.
        send_item(ndtm_pkg::OP_CLUSTER, 16'd1100);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd1100);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd7);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        // A frame with no clusters empties the list.
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd5);
    endtask

    // Register extremes: match ceiling, zero rate, static threshold above fast.
    task automatic test_register_corners();
        load_config(255, 65535, 0, 24'hFFFFFF);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd40965);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd40964);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        load_config(0, 0, 5000, 100);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd40965);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd40963);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
        load_config(1, 100, 50, 20);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd40915);
        send_item(ndtm_pkg::OP_CLUSTER, 16'd41030);
        send_item(ndtm_pkg::OP_FRAME_END, 16'd0);
    endtask

    task automatic test_random_frames();
        for (int phase = 0; phase < 6; phase++)
        begin
            random_config();
            tx_gap_pct = (phase % 3 == 0) ? 0 : 10 * (phase % 3);
            rx_gap_pct = (phase % 3 == 1) ? 0 : 15 * (phase % 3 + 1);
            run_frames(280);
        end
    endtask

    // The receiver stops for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        s_tvalid   <= 1'b0;
        tx_gap_pct = 0;
        @(negedge clk);
        rx_hold_left = RX_HOLD_CYCLES;
        @(posedge clk);
        run_frames(40);
    endtask

    task automatic test_full_rate();
        s_tvalid <= 1'b0;
        @(negedge clk);
        idle_on = 1'b0;
        @(posedge clk);
        run_frames(200);
    endtask

    // Result checker and receiver-side ready pattern.
    initial
    begin
        speed_report_t due;
        m_tready     <= 1'b0;
        rx_hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                begin
                    if (speed_reports_due.size() == 0)
                    begin
                        report_mismatch($sformatf("unexpected result speed=%0d class=%0d",
                                                  m_tdata, m_tuser));
                    end
                    else
                    begin
                        due = speed_reports_due.pop_front();
                        if (m_tdata !== due.speed)
                            report_mismatch($sformatf("speed %0d, expected %0d",
                                                      m_tdata, due.speed));
                        if (m_tuser !== due.cls)
                            report_mismatch($sformatf("class %0d, expected %0d",
                                                      m_tuser, due.cls));
                    end
                end
                if (rx_hold_left > 0)
                begin
                    rx_hold_left--;
                    m_tready <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 99) < rx_gap_pct)
                begin
                    rx_hold_left = $urandom_range(1, 19) - 1;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ndtm_pkg::OP_CLUSTER;
        cfg_valid <= 1'b0;
        cfg_index <= ndtm_pkg::REG_FRAME_RATE;
        cfg_data  <= '0;
        cfg.frame_rate_hz  = ndtm_pkg::FRAME_RATE_RST;
        cfg.movement_limit = ndtm_pkg::MOVEMENT_LIMIT_RST;
        cfg.static_speed   = ndtm_pkg::STATIC_SPEED_RST;
        cfg.fast_speed     = ndtm_pkg::FAST_SPEED_RST;
        for (int i = 0; i < MAX_TRACKED; i++)
            prev_live[i] = 1'b0;
        clusters_in_frame = 0;
        mismatches = 0;
        idle_on    = 1'b1;
        tx_gap_pct = 20;
        rx_gap_pct = 20;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_register_corners();
        test_random_frames();
        test_output_backpressure();
        test_full_rate();

        wait_idle();
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ndtm_pkg.sv
hw/rtl/ndtm_cfg_regs.sv
hw/rtl/ndtm_match_unit.sv
hw/rtl/ndtm_classify.sv
hw/rtl/nearest_distance_track_matcher.sv
tb/sv/tb_top.sv
